// ----- rtl/core/arxt_pkg.sv -----
// Package: shared constants, types and codes for the address range exclusion table.
`timescale 1ns / 1ps
`default_nettype none
package arxt_pkg;
  localparam int TableEntries = 16;
  localparam int IdxW = $clog2(TableEntries);
  localparam int CntW = $clog2(TableEntries + 1);
  localparam int GuardW = $clog2(TableEntries + 3);
  localparam logic [63:0] AllOnes = '1;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_REMOVE = 3'd1,
    OP_RQUERY = 3'd2,
    OP_PQUERY = 3'd3,
    OP_GAP = 3'd4
  } op_t;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_step;
    logic append;
    logic gap_jump;
    logic commit_count;
    logic res_load;
    logic res_hit;
    logic res_found;
    logic res_warn;
    logic res_status;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic full;
    logic scan_done;
    logic match;
    logic cur_ones;
    logic wrap;
    logic guard_done;
  } sts_t;
endpackage
`default_nettype wire

// ----- rtl/core/arxt_if.sv -----
// Interfaces: valid/ready channels for request and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface arxt_req_if;
  logic valid;
  logic ready;
  logic [2:0] operation;
  logic [63:0] range_start;
  logic [63:0] range_limit;
  logic [63:0] point_addr;
  logic [7:0] owner_tag;
  logic zone_kind;
  logic [63:0] alloc_size;
  logic [63:0] search_start;
  modport source(output valid, operation, range_start, range_limit, point_addr, owner_tag,
                 zone_kind, alloc_size, search_start, input ready);
  modport sink(input valid, operation, range_start, range_limit, point_addr, owner_tag,
               zone_kind, alloc_size, search_start, output ready);
endinterface

interface arxt_rsp_if;
  logic valid;
  logic ready;
  logic hit;
  logic found;
  logic [63:0] found_addr;
  logic overlap_warning;
  logic status;
  modport source(output valid, hit, found, found_addr, overlap_warning, status,
                 input ready);
  modport sink(input valid, hit, found, found_addr, overlap_warning, status,
               output ready);
endinterface
`default_nettype wire

// ----- rtl/core/arxt_datapath.sv -----
// Datapath: entry registers, scan pointer, compare unit and result register.
`timescale 1ns / 1ps
`default_nettype none
module arxt_datapath (
  input wire logic clk,
  input wire logic rst,
  arxt_req_if.sink req,
  arxt_rsp_if.source rsp,
  input wire arxt_pkg::cmd_t cmd,
  output arxt_pkg::sts_t sts
);
  logic [63:0] e_start [arxt_pkg::TableEntries];
  logic [63:0] e_end [arxt_pkg::TableEntries];
  logic [7:0] e_owner [arxt_pkg::TableEntries];
  logic e_kind [arxt_pkg::TableEntries];
  logic [arxt_pkg::CntW-1:0] count, rd, wr;
  logic [arxt_pkg::GuardW-1:0] guard;
  logic [2:0] op;
  logic [63:0] a, b, pt, size, cur;
  logic [7:0] owner;
  logic kind;
  logic rv, r_hit, r_found, r_warn, r_status;
  logic [63:0] r_addr;
  logic [arxt_pkg::IdxW-1:0] ri, wi, ci;
  logic [63:0] s_i, e_i, stop;
  logic ovl, cont, own_eq;

  assign ri = rd[arxt_pkg::IdxW-1:0];
  assign wi = wr[arxt_pkg::IdxW-1:0];
  assign ci = count[arxt_pkg::IdxW-1:0];
  assign s_i = e_start[ri];
  assign e_i = e_end[ri];
  assign stop = cur + size;
  assign own_eq = e_owner[ri] == owner;
  always_comb begin
    ovl = 1'b0;
    cont = 1'b0;
    if (op == arxt_pkg::OP_GAP) ovl = (cur < e_i) && (stop > s_i);
    else ovl = (a < e_i) && (b > s_i);
    cont = (s_i <= pt) && (pt < e_i);
  end

  always_comb begin
    sts.op = op;
    sts.full = count >= arxt_pkg::CntW'(arxt_pkg::TableEntries);
    sts.scan_done = rd >= count;
    case (op)
      arxt_pkg::OP_PQUERY: sts.match = cont;
      arxt_pkg::OP_REMOVE: sts.match = own_eq;
      default: sts.match = ovl;
    endcase
    sts.cur_ones = cur == arxt_pkg::AllOnes;
    sts.wrap = (e_i + size) < e_i;
    sts.guard_done = guard > arxt_pkg::GuardW'(arxt_pkg::TableEntries + 1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= req.operation; a <= req.range_start; b <= req.range_limit;
      pt <= req.point_addr; owner <= req.owner_tag; kind <= req.zone_kind;
      size <= req.alloc_size; cur <= req.search_start;
    end
    if (cmd.append) begin
      e_start[ci] <= a; e_end[ci] <= b; e_owner[ci] <= owner; e_kind[ci] <= kind;
    end
    if (cmd.scan_step && op == arxt_pkg::OP_REMOVE && !own_eq) begin
      e_start[wi] <= e_start[ri]; e_end[wi] <= e_end[ri];
      e_owner[wi] <= e_owner[ri]; e_kind[wi] <= e_kind[ri];
    end
    if (cmd.gap_jump) cur <= e_i;
    if (cmd.res_load) begin
      r_hit <= cmd.res_hit; r_found <= cmd.res_found; r_warn <= cmd.res_warn;
      r_status <= cmd.res_status; r_addr <= cmd.res_found ? cur : arxt_pkg::AllOnes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; rd <= '0; wr <= '0; guard <= '0; rv <= 1'b0;
    end else begin
      if (cmd.load) guard <= '0;
      if (cmd.scan_clr) begin
        rd <= '0; wr <= '0;
      end else if (cmd.scan_step) begin
        rd <= rd + 1'b1;
        if (op == arxt_pkg::OP_REMOVE && !own_eq) wr <= wr + 1'b1;
      end
      if (cmd.gap_jump) begin
        rd <= '0; guard <= guard + 1'b1;
      end
      if (cmd.append) count <= count + 1'b1;
      if (cmd.commit_count) count <= wr;
      if (cmd.res_load) rv <= 1'b1;
      else if (rsp.ready) rv <= 1'b0;
    end
  end

  assign req.ready = cmd.load;
  assign rsp.valid = rv;
  assign rsp.hit = r_hit;
  assign rsp.found = r_found;
  assign rsp.found_addr = r_addr;
  assign rsp.overlap_warning = r_warn;
  assign rsp.status = r_status;
  logic unused_kind;
  assign unused_kind = e_kind[0];
endmodule
`default_nettype wire

// ----- rtl/core/arxt_ctrl.sv -----
// Controller: sequences scans, appends, compaction and gap-search jumps.
`timescale 1ns / 1ps
`default_nettype none
module arxt_ctrl (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic rsp_busy,
  input wire arxt_pkg::sts_t sts,
  output arxt_pkg::cmd_t cmd
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_GAP = 4'b0100, S_DONE = 4'b1000
  } state_t;
  state_t state, state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.load = !rsp_busy;
        if (req_valid && !rsp_busy) begin
          cmd.scan_clr = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        case (sts.op)
          arxt_pkg::OP_ADD: begin
            cmd.res_load = 1'b1;
            state_next = S_IDLE;
            if (sts.full) cmd.res_status = 1'b1;
            else if (sts.scan_done) cmd.append = 1'b1;
            else if (sts.match) begin
              cmd.res_warn = 1'b1; cmd.append = 1'b1;
            end else begin
              cmd.res_load = 1'b0; cmd.scan_step = 1'b1; state_next = S_SCAN;
            end
          end
          arxt_pkg::OP_REMOVE: begin
            if (sts.scan_done) begin
              cmd.commit_count = 1'b1; cmd.res_load = 1'b1; state_next = S_IDLE;
            end else cmd.scan_step = 1'b1;
          end
          arxt_pkg::OP_RQUERY, arxt_pkg::OP_PQUERY: begin
            if (sts.scan_done || sts.match) begin
              cmd.res_load = 1'b1; cmd.res_hit = !sts.scan_done; state_next = S_IDLE;
            end else cmd.scan_step = 1'b1;
          end
          arxt_pkg::OP_GAP: state_next = S_GAP;
          default: begin
            cmd.res_load = 1'b1; state_next = S_IDLE;
          end
        endcase
      end
      S_GAP: begin
        if (sts.cur_ones || sts.guard_done) begin
          cmd.res_load = 1'b1; state_next = S_IDLE;
        end else if (sts.scan_done) begin
          cmd.res_load = 1'b1; cmd.res_found = 1'b1; state_next = S_IDLE;
        end else if (sts.match) begin
          cmd.gap_jump = 1'b1;
          if (sts.wrap) state_next = S_DONE;
        end else cmd.scan_step = 1'b1;
      end
      S_DONE: begin
        cmd.res_load = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule
`default_nettype wire

// ----- rtl/core/address_range_exclusion_table_top.sv -----
// Top level: address range exclusion table.
// One beat in flight: next request taken once the result register is empty.
// Throughput is set by the single entry-compare unit scanned one entry a cycle.
// Synchronous active-high reset empties the table and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none
module address_range_exclusion_table_top (
  input wire logic clk,
  input wire logic rst,
  arxt_req_if.sink req,
  arxt_rsp_if.source rsp
);
  arxt_pkg::cmd_t cmd;
  arxt_pkg::sts_t sts;
  arxt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_valid(req.valid), .rsp_busy(rsp.valid), .sts(sts), .cmd(cmd)
  );
  arxt_datapath u_dp (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cmd(cmd), .sts(sts));
endmodule
`default_nettype wire

// ----- rtl/core/arxt_checker.sv -----
// Checker: port-level properties of the table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module arxt_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire logic found,
  input wire logic [63:0] found_addr,
  input wire logic status,
  input wire logic overlap_warning
);
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("accept with pending result");
  a_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !found |-> found_addr == '1) else $error("bad found_addr");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(status && overlap_warning)) else $error("status with warning");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(found_addr)) else $error("beat dropped");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !rsp_valid) else $error("result too early");
endmodule

bind address_range_exclusion_table_top arxt_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .found(rsp.found),
  .found_addr(rsp.found_addr), .status(rsp.status), .overlap_warning(rsp.overlap_warning)
);
`default_nettype wire
